// ===== rtl/kwm_pkg.sv =====
// Shared constants, types and helpers for the keyword rule matcher.
// No dependencies; imported by kwm_term, the core top level and the testbench.
package kwm_pkg;

	localparam int NUM_RULES      = 16;
	localparam int TERMS_PER_RULE = 2;
	localparam int TERM_LEN       = 32;
	localparam int NUM_TERMS      = NUM_RULES * TERMS_PER_RULE;

	localparam int RULE_W = $clog2(NUM_RULES);
	localparam int TERM_W = (TERMS_PER_RULE > 1) ? $clog2(TERMS_PER_RULE) : 1;
	localparam int POS_W  = $clog2(TERM_LEN);
	localparam int LEN_W  = $clog2(TERM_LEN + 1);
	localparam int CFG_W  = 5;

	localparam logic [1:0] OP_WRITE_BYTE = 2'd0;
	localparam logic [1:0] OP_SET_LEN    = 2'd1;
	localparam logic [1:0] OP_SCAN       = 2'd2;

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] ASCII_CASE    = 8'h20;

	// broadcast from the core to every term cell
	typedef struct packed {
		logic             scan;
		logic             clear;
		logic             wr_byte;
		logic             wr_len;
		logic [POS_W-1:0] pos;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
	} term_ctl_t;

	typedef struct packed {
		logic seen_q;  // sticky flag as stored
		logic found;   // flag including the byte in flight
		logic empty;   // zero-length term
	} term_sts_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			r = c + ASCII_CASE;
		end
		return r;
	endfunction

endpackage

// ===== rtl/kwm_term.sv =====
// One keyword term: byte cells, length, shift-and prefix vector, seen flag.
// Depends on kwm_pkg.
module kwm_term
	import kwm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  term_ctl_t ctl,
	input  logic      sel,
	input  logic      fold,
	output term_sts_t sts
);

	logic [7:0]          bytes_q [TERM_LEN];
	logic [LEN_W-1:0]    len_q;
	logic [TERM_LEN-1:0] prefix_q;
	logic                seen_q;

	logic [TERM_LEN-1:0] match;
	logic [TERM_LEN-1:0] prefix_nxt;
	logic [LEN_W-1:0]    len_m1;
	logic                hit;
	logic [7:0]          cc;
	logic [LEN_W-1:0]    len_sat;

	always_comb begin
		cc = fold ? fold_byte(ctl.data) : ctl.data;
		for (int j = 0; j < TERM_LEN; j++) begin
			match[j] = ((fold ? fold_byte(bytes_q[j]) : bytes_q[j]) == cc)
				&& (LEN_W'(j) < len_q);
		end
		prefix_nxt = {prefix_q[TERM_LEN-2:0], 1'b1} & match;
		len_m1     = len_q - LEN_W'(1);
		hit        = (len_q != '0) && prefix_nxt[len_m1[POS_W-1:0]];
		len_sat    = (ctl.len > LEN_W'(TERM_LEN)) ? LEN_W'(TERM_LEN) : ctl.len;
	end

	assign sts.seen_q = seen_q;
	assign sts.found  = seen_q | (ctl.scan & hit);
	assign sts.empty  = (len_q == '0);

	// term bytes carry no reset
	always_ff @(posedge clk) begin
		if (ctl.wr_byte && sel) begin
			bytes_q[ctl.pos] <= ctl.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			prefix_q <= '0;
			seen_q   <= 1'b0;
		end else begin
			if (ctl.wr_len && sel) begin
				len_q <= len_sat;
			end
			if (ctl.clear) begin
				prefix_q <= '0;
				seen_q   <= 1'b0;
			end else if (ctl.scan) begin
				prefix_q <= prefix_nxt;
				seen_q   <= seen_q | hit;
			end
		end
	end

endmodule

// ===== rtl/multi_term_keyword_rule_matcher_core.sv =====
// Keyword rule matcher core: input register, term cell array, result register.
// Depends on kwm_pkg and kwm_term.
// Result path: the last scan byte is taken into the input register, its verdict into the result register.
// Throughput: one item per cycle; a buffer-ending byte waits only while the result is held.
// Reset: clears handshake state, term lengths, prefix vectors, seen flags and rules_in_use;
// every rule's case mode goes to folding. Term bytes are not reset.
module multi_term_keyword_rule_matcher_core
	import kwm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// config
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	// input channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       op,
	input  logic [3:0]       rule_index,
	input  logic [0:0]       term_index,
	input  logic [4:0]       char_position,
	input  logic [7:0]       char_value,
	input  logic [5:0]       term_length,
	input  logic             case_fold,
	input  logic             last,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic             detected,
	output logic [3:0]       rule_number
);

	// ---------------- input stage ----------------
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [RULE_W-1:0] rule_s1;
	logic [TERM_W-1:0] term_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [7:0]        char_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              fold_s1;
	logic              last_s1;

	// ---------------- result register ----------------
	logic              out_valid_q;
	logic              detected_q;
	logic [RULE_W-1:0] rule_number_q;

	logic [CFG_W-1:0]     rules_in_use_q;
	logic [NUM_RULES-1:0] fold_q;

	logic      res_s1;   // item in stage 1 produces a result
	logic      s1_adv;   // stage 1 may retire this cycle
	logic      fire;     // stage 1 item is applied
	logic      addr_ok;
	term_ctl_t ctl;

	term_sts_t            sts      [NUM_TERMS];
	logic [NUM_TERMS-1:0] sel;
	logic [NUM_TERMS-1:0] seen_vec;
	logic [NUM_RULES-1:0] rule_hit;
	logic                 det_c;
	logic [RULE_W-1:0]    num_c;

	assign res_s1   = (op_s1 == OP_SCAN) && last_s1;
	// a result-free item always retires; one with a result needs the output slot
	assign s1_adv   = !res_s1 || !out_valid_q || out_ready;
	assign fire     = valid_s1 && s1_adv;
	assign in_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			rule_s1 <= rule_index;
			term_s1 <= term_index;
			pos_s1  <= char_position;
			char_s1 <= char_value;
			len_s1  <= term_length;
			fold_s1 <= case_fold;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_in_use_q <= '0;
		end else if (cfg_we) begin
			rules_in_use_q <= cfg_data;
		end
	end

	// per-rule case mode, folding after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= '1;
		end else if (fire && (op_s1 == OP_SET_LEN) && addr_ok) begin
			fold_q[rule_s1] <= fold_s1;
		end
	end

	// loads outside the table are dropped
	assign addr_ok = (int'(rule_s1) < NUM_RULES) && (int'(term_s1) < TERMS_PER_RULE);

	always_comb begin
		ctl.scan    = fire && (op_s1 == OP_SCAN);
		ctl.clear   = fire && res_s1;
		ctl.wr_byte = fire && (op_s1 == OP_WRITE_BYTE) && (int'(pos_s1) < TERM_LEN);
		ctl.wr_len  = fire && (op_s1 == OP_SET_LEN);
		ctl.pos     = pos_s1;
		ctl.data    = char_s1;
		ctl.len     = len_s1;
	end

	// ---------------- term cell array ----------------
	for (genvar t = 0; t < NUM_TERMS; t++) begin : g_term
		assign sel[t] = addr_ok
			&& (rule_s1 == RULE_W'(t / TERMS_PER_RULE))
			&& (term_s1 == TERM_W'(t % TERMS_PER_RULE));
		assign seen_vec[t] = sts[t].seen_q;

		kwm_term u_term (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sel    (sel[t]),
			.fold   (fold_q[t / TERMS_PER_RULE]),
			.sts    (sts[t])
		);
	end

	// ---------------- rule evaluation ----------------
	// A rule matches when it is active and each of its terms is either
	// zero-length or seen, counting the byte now being scanned.
	always_comb begin
		for (int r = 0; r < NUM_RULES; r++) begin
			rule_hit[r] = (CFG_W'(r) < rules_in_use_q);
			for (int k = 0; k < TERMS_PER_RULE; k++) begin
				rule_hit[r] = rule_hit[r]
					&& (sts[r * TERMS_PER_RULE + k].empty
					|| sts[r * TERMS_PER_RULE + k].found);
			end
		end
		// lowest index wins
		det_c = 1'b0;
		num_c = '0;
		for (int r = NUM_RULES - 1; r >= 0; r--) begin
			if (rule_hit[r]) begin
				det_c = 1'b1;
				num_c = RULE_W'(r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_s1) begin
			detected_q    <= det_c;
			rule_number_q <= num_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign detected    = detected_q;
	assign rule_number = rule_number_q;

	// ---------------- assertions ----------------
	a_num_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (detected_q || rule_number_q == '0))
		else $error("rule_number nonzero without detection");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && res_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	a_scan_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_s1) |=> (seen_vec == '0))
		else $error("seen flags not cleared after buffer end");

endmodule

// ===== test/multi_term_keyword_rule_matcher_core_tb.sv =====
// Self-checking testbench for multi_term_keyword_rule_matcher_core: loads rule tables,
// streams scan buffers with random handshake gaps and checks every verdict item.
// Depends on kwm_pkg and the core RTL only.
module multi_term_keyword_rule_matcher_core_tb;
	import kwm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// op 3 has no function in the block; it must be swallowed without a result
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam int QUIET_CYCLES = 4;   // the input and result registers must drain, keep margin
	localparam int END_CYCLES   = 8;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] rule;
		logic [0:0] term;
		logic [4:0] pos;
		logic [7:0] chr;
		logic [5:0] len;
		logic       fold;
		logic       last;
	} item_t;

	typedef struct {
		logic       detected;
		logic [3:0] rule_number;
	} verdict_t;

	// what the driver pulls off its queue: an input item, a rules_in_use
	// write, or a hold until every verdict has come back
	typedef enum logic [1:0] {ENTRY_ITEM, ENTRY_RULES, ENTRY_HOLD} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		item_t       body;
		logic [4:0]  rules;
	} entry_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [4:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	item_t      drv = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       detected;
	logic [3:0] rule_number;

	multi_term_keyword_rule_matcher_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (drv.op),
		.rule_index    (drv.rule),
		.term_index    (drv.term),
		.char_position (drv.pos),
		.char_value    (drv.chr),
		.term_length   (drv.len),
		.case_fold     (drv.fold),
		.last          (drv.last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.detected      (detected),
		.rule_number   (rule_number)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Predictor: a private copy of the rule table and the scan state
	// ------------------------------------------------------------------
	logic [7:0]          tbl_bytes [NUM_TERMS][TERM_LEN];
	logic [5:0]          tbl_len [NUM_TERMS];
	bit                  tbl_fold [NUM_RULES];
	logic [TERM_LEN-1:0] prefix_vec [NUM_TERMS];
	bit                  term_hit [NUM_TERMS];
	logic [4:0]          rules_active;

	verdict_t verdicts_due [$];
	int       mismatches = 0;

	function automatic logic [7:0] lower_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	task automatic rule_table_apply(input item_t it);
		int                  t;
		int                  j;
		int                  r;
		int                  k;
		int                  active;
		int                  tk;
		bit                  fold_on;
		bit                  all_seen;
		logic [7:0]          cc;
		logic [7:0]          pc;
		logic [TERM_LEN-1:0] hit_mask;
		verdict_t            v;
		t = it.rule * TERMS_PER_RULE + it.term;
		case (it.op)
			OP_WRITE_BYTE: tbl_bytes[t][it.pos] = it.chr;
			OP_SET_LEN: begin
				// lengths past the term storage saturate
				tbl_len[t] = (it.len > TERM_LEN) ? 6'(TERM_LEN) : it.len;
				tbl_fold[it.rule] = it.fold;
			end
			OP_SCAN: begin
				// shift-and step for every term in parallel
				for (t = 0; t < NUM_TERMS; t++) begin
					fold_on = tbl_fold[t / TERMS_PER_RULE];
					cc = fold_on ? lower_letter(it.chr) : it.chr;
					hit_mask = '0;
					for (j = 0; j < tbl_len[t]; j++) begin
						pc = fold_on ? lower_letter(tbl_bytes[t][j]) : tbl_bytes[t][j];
						if (pc == cc) begin
							hit_mask[j] = 1'b1;
						end
					end
					prefix_vec[t] = ((prefix_vec[t] << 1) | 1) & hit_mask;
					if (tbl_len[t] != 0 && prefix_vec[t][tbl_len[t] - 1]) begin
						term_hit[t] = 1'b1;
					end
				end
				if (it.last) begin
					// lowest active rule whose non-empty terms were all seen;
					// rules_in_use above the table size counts as the full table
					active = (rules_active > NUM_RULES) ? NUM_RULES : rules_active;
					v.detected = 1'b0;
					v.rule_number = '0;
					for (r = 0; r < active && !v.detected; r++) begin
						all_seen = 1'b1;
						for (k = 0; k < TERMS_PER_RULE; k++) begin
							tk = r * TERMS_PER_RULE + k;
							if (tbl_len[tk] != 0 && !term_hit[tk]) begin
								all_seen = 1'b0;
							end
						end
						if (all_seen) begin
							v.detected = 1'b1;
							v.rule_number = 4'(r);
						end
					end
					verdicts_due = {verdicts_due, v};
					for (t = 0; t < NUM_TERMS; t++) begin
						prefix_vec[t] = '0;
						term_hit[t] = 1'b0;
					end
				end
			end
			default: ;  // reserved op: nothing changes
		endcase
	endtask

	task automatic note_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Rising edge: sample both handshakes, check verdicts, feed predictor
	// ------------------------------------------------------------------
	logic in_fire = 1'b0;

	always @(posedge clk) begin
		verdict_t want;
		in_fire = 1'b0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					note_mismatch($sformatf("verdict item with nothing expected (detected %b rule %0d)",
						detected, rule_number));
				end else begin
					want = verdicts_due.pop_front();
					if (detected !== want.detected) begin
						note_mismatch($sformatf("detected %b, expected %b", detected, want.detected));
					end
					if (rule_number !== want.rule_number) begin
						note_mismatch($sformatf("rule_number %0d, expected %0d",
							rule_number, want.rule_number));
					end
				end
			end
			if (cfg_we) begin
				rules_active = cfg_data;
			end
			in_fire = in_valid && in_ready;
			if (in_fire) begin
				rule_table_apply(drv);
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: bursts of items with random gaps. Register writes and holds
	// wait until the block has drained and no verdict has been due for QUIET_CYCLES.
	// ------------------------------------------------------------------
	entry_t pending [$];
	int     burst_left = 8;
	int     gap_left = 0;
	int     quiet_cycles = 0;

	always @(negedge clk) begin
		logic   nxt_valid;
		logic   nxt_we;
		item_t  nxt_item;
		entry_t e;
		nxt_valid = in_valid && !in_fire;
		nxt_we    = 1'b0;
		nxt_item  = drv;
		if (arst_n && !nxt_valid && pending.size() != 0) begin
			if (pending[0].kind != ENTRY_ITEM) begin
				quiet_cycles = (verdicts_due.size() == 0) ? quiet_cycles + 1 : 0;
				if (quiet_cycles >= QUIET_CYCLES) begin
					e = pending.pop_front();
					if (e.kind == ENTRY_RULES) begin
						nxt_we = 1'b1;
						cfg_data <= e.rules;
					end
					quiet_cycles = 0;
				end
			end else if (gap_left != 0) begin
				gap_left--;
			end else begin
				e = pending.pop_front();
				nxt_item  = e.body;
				nxt_valid = 1'b1;
				quiet_cycles = 0;
				if (burst_left <= 1) begin
					// mostly short bursts, now and then a long unbroken run
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
		in_valid <= nxt_valid;
		drv      <= nxt_item;
		cfg_we   <= nxt_we;
	end

	// Receiver: switches between always ready, coin flips and stall runs
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_mode_left = 0;
	int       rx_stall_left = 0;

	always @(negedge clk) begin
		logic rdy;
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_mode_left = $urandom_range(20, 120);
		end else begin
			rx_mode_left--;
		end
		case (rx_mode)
			RX_OPEN: rdy = 1'b1;
			RX_COIN: rdy = 1'($urandom_range(0, 1));
			default: begin
				if (rx_stall_left != 0) begin
					rdy = 1'b0;
					rx_stall_left--;
				end else begin
					rdy = 1'b1;
					if ($urandom_range(0, 3) == 0) begin
						rx_stall_left = $urandom_range(1, 8);
					end
				end
			end
		endcase
		out_ready <= rdy;
	end

	// ------------------------------------------------------------------
	// Stimulus. plan_* shadow the table as the generator leaves it, so that
	// no term length ever reaches a byte that was not written, and so that
	// scan buffers can carry real term text.
	// ------------------------------------------------------------------
	logic [7:0] plan_bytes [NUM_TERMS][TERM_LEN];
	bit         plan_loaded [NUM_TERMS][TERM_LEN];
	int         plan_len [NUM_TERMS];
	bit         plan_fold [NUM_RULES];
	int         gen_count = 0;

	function automatic item_t noise_item();
		logic [31:0] r;
		r = $urandom;
		return r[27:0];
	endfunction

	// small alphabet so partial matches are common; includes the bytes just
	// outside A..Z and a..z and a high byte pair that must not fold
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 13))
			0:       return "a";
			1:       return "A";
			2:       return "b";
			3:       return "B";
			4:       return "z";
			5:       return "Z";
			6:       return 8'h40;
			7:       return 8'h5B;
			8:       return 8'h60;
			9:       return 8'h7B;
			10:      return 8'hC1;
			11:      return 8'hE1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_entry(input entry_kind_t kind, input item_t body, input logic [4:0] rules);
		entry_t e;
		e.kind  = kind;
		e.body  = body;
		e.rules = rules;
		pending = {pending, e};
	endtask

	task automatic push_item(input item_t it);
		add_entry(ENTRY_ITEM, it, '0);
		if (it.op != OP_RESERVED) begin
			gen_count++;
		end
	endtask

	task automatic set_rules(input int n);
		add_entry(ENTRY_RULES, '0, 5'(n));
	endtask

	task automatic load_byte(input int rule, input int term, input int pos, input logic [7:0] val);
		item_t it;
		int    t;
		it = noise_item();
		it.op   = OP_WRITE_BYTE;
		it.rule = 4'(rule);
		it.term = 1'(term);
		it.pos  = 5'(pos);
		it.chr  = val;
		t = rule * TERMS_PER_RULE + term;
		plan_bytes[t][pos] = val;
		plan_loaded[t][pos] = 1'b1;
		push_item(it);
	endtask

	// writes any missing bytes below the length first
	task automatic load_term(input int rule, input int term, input int len, input bit fold);
		item_t it;
		int    t;
		int    p;
		int    n;
		t = rule * TERMS_PER_RULE + term;
		n = (len > TERM_LEN) ? TERM_LEN : len;
		for (p = 0; p < n; p++) begin
			if (!plan_loaded[t][p]) begin
				load_byte(rule, term, p, pick_char());
			end
		end
		it = noise_item();
		it.op   = OP_SET_LEN;
		it.rule = 4'(rule);
		it.term = 1'(term);
		it.len  = 6'(len);
		it.fold = fold;
		plan_len[t] = n;
		plan_fold[rule] = fold;
		push_item(it);
	endtask

	task automatic random_load();
		int rule;
		int len;
		int pick;
		rule = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_RULES - 1) : $urandom_range(0, 4);
		pick = $urandom_range(0, 39);
		if (pick < 28) begin
			len = $urandom_range(0, 4);
		end else if (pick < 36) begin
			len = $urandom_range(5, 12);
		end else if (pick < 38) begin
			len = $urandom_range(13, 31);
		end else begin
			len = $urandom_range(32, 63);  // saturates to the full term
		end
		load_term(rule, $urandom_range(0, 1), len, 1'($urandom_range(0, 1)));
	endtask

	// one buffer; optionally a table load lands between two of its bytes
	task automatic push_scan(input logic [7:0] bytes_q [$], input bit mid_load);
		item_t it;
		int    k;
		int    cut;
		cut = mid_load ? $urandom_range(0, bytes_q.size() - 1) : -1;
		for (k = 0; k < bytes_q.size(); k++) begin
			if (k == cut) begin
				random_load();
			end
			if ($urandom_range(0, 29) == 0) begin
				it = noise_item();
				it.op = OP_RESERVED;
				push_item(it);
			end
			it = noise_item();
			it.op   = OP_SCAN;
			it.chr  = bytes_q[k];
			it.last = (k == bytes_q.size() - 1);
			push_item(it);
		end
	endtask

	// filler around copies of loaded terms, with case flips and the odd
	// corrupted byte so that some terms only nearly match
	task automatic scan_stream(input int n_embed, input bit mid_load);
		logic [7:0] stream_q [$];
		logic [7:0] c;
		int         k;
		int         p;
		int         t;
		for (k = 0; k < n_embed; k++) begin
			repeat ($urandom_range(0, 3)) stream_q = {stream_q, pick_char()};
			t = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 9) : $urandom_range(0, NUM_TERMS - 1);
			for (p = 0; p < plan_len[t]; p++) begin
				c = plan_bytes[t][p];
				if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z"
					&& $urandom_range(0, plan_fold[t / TERMS_PER_RULE] ? 1 : 7) == 0) begin
					c = c ^ 8'h20;
				end
				stream_q = {stream_q, c};
			end
			if ($urandom_range(0, 9) == 0 && stream_q.size() != 0) begin
				stream_q[$urandom_range(0, stream_q.size() - 1)] = pick_char();
			end
		end
		repeat ($urandom_range(0, 3)) stream_q = {stream_q, pick_char()};
		if (stream_q.size() == 0) begin
			stream_q = {stream_q, pick_char()};
		end
		push_scan(stream_q, mid_load);
	endtask

	initial begin
		int    ph;
		int    pick;
		bit    held;
		item_t it;
		int    rules_plan [8];

		// predictor and generator start from the reset state of the block
		rules_active = '0;
		for (int t = 0; t < NUM_TERMS; t++) begin
			tbl_len[t] = '0;
			prefix_vec[t] = '0;
			term_hit[t] = 1'b0;
			plan_len[t] = 0;
			for (int p = 0; p < TERM_LEN; p++) begin
				plan_loaded[t][p] = 1'b0;
			end
		end
		for (int r = 0; r < NUM_RULES; r++) begin
			tbl_fold[r] = 1'b1;
			plan_fold[r] = 1'b1;
		end

		// --- directed part ---
		it = noise_item();
		it.op = OP_RESERVED;
		push_item(it);                          // reserved op, no result
		push_scan('{"q"}, 1'b0);                // scanner not set up: never detects
		set_rules(NUM_RULES);
		push_scan('{"z"}, 1'b0);                // all terms empty: rule 0 hits
		load_byte(0, 0, 0, "A");
		load_byte(0, 0, 1, "b");
		load_term(0, 0, 2, 1'b1);
		push_scan('{"a", "B"}, 1'b0);           // folded match on rule 0
		load_term(0, 0, 2, 1'b0);
		push_scan('{"a", "B"}, 1'b0);           // exact case now fails, empty rule 1 wins
		push_scan('{"A"}, 1'b0);                // term longer than the buffer
		load_byte(1, 0, 0, 8'hC1);
		load_term(1, 0, 1, 1'b1);
		push_scan('{8'hE1}, 1'b0);              // high bytes never fold, rule 2 wins
		load_byte(0, 1, TERM_LEN - 1, 8'hFF);   // top byte position
		set_rules(1);
		push_scan('{"A", "b"}, 1'b0);           // exact match on rule 0
		push_scan('{"z"}, 1'b0);                // only rule 0 active: nothing

		// --- random part: one rules_in_use setting per phase ---
		rules_plan = '{31, 0, 16, 1, 2, 16, 4, 31};
		rules_plan[6] = $urandom_range(0, 31);
		held = 1'b0;
		for (ph = 0; ph < 8; ph++) begin
			set_rules(rules_plan[ph]);
			while (gen_count < 25 + (ph + 1) * 85) begin
				if (ph == 3 && !held && gen_count >= 25 + 3 * 85 + 40) begin
					// let the block drain completely before going on
					add_entry(ENTRY_HOLD, '0, '0);
					held = 1'b1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					random_load();
				end else if (pick < 16) begin
					load_byte($urandom_range(0, NUM_RULES - 1), $urandom_range(0, 1),
						$urandom_range(0, TERM_LEN - 1), pick_char());
				end else if (pick < 19) begin
					it = noise_item();
					it.op = OP_RESERVED;
					push_item(it);
				end else begin
					scan_stream($urandom_range(0, 3), $urandom_range(0, 9) == 0);
				end
			end
		end

		// reset: released at a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid) @(posedge clk);
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("multi_term_keyword_rule_matcher_core_tb OK");
		end else begin
			$display("multi_term_keyword_rule_matcher_core_tb NOT OK");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("ERROR: timeout with %0d items pending, %0d verdicts due",
			pending.size(), verdicts_due.size());
		$display("multi_term_keyword_rule_matcher_core_tb NOT OK");
		$finish;
	end

endmodule

// ===== multi_term_keyword_rule_matcher_core.f =====
rtl/kwm_pkg.sv
rtl/kwm_term.sv
rtl/multi_term_keyword_rule_matcher_core.sv
test/multi_term_keyword_rule_matcher_core_tb.sv
